// File: sv/pipct_pkg.sv
// Shared types and constants for the point-in-polygon crossing test.
`timescale 1ns / 1ps
package pipct_pkg;

    typedef enum logic {
        CFG_QUERY_X = 1'b0,
        CFG_QUERY_Y = 1'b1
    } t_cfg_idx;

    localparam int NUM_EDGES  = 2;
    localparam int EDGE_OPEN  = 0;
    localparam int EDGE_CLOSE = 1;

    typedef struct packed {
        logic direct;
        logic straddle;
        logic down;
    } t_edge_flags;

    typedef struct packed {
        logic toggle;
        logic hit;
    } t_edge_verdict;

endpackage

// File: sv/pipct_vtx_if.sv
// Vertex channel: valid/ready handshake with one polygon vertex per word.
`timescale 1ns / 1ps
interface pipct_vtx_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                    output ready);
endinterface

// File: sv/pipct_res_if.sv
// Result channel: valid/ready handshake with one polygon verdict per word.
`timescale 1ns / 1ps
interface pipct_res_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic on_contour;

    modport source (output valid, output inside_res, output on_contour, input ready);
    modport sink   (input valid, input inside_res, input on_contour, output ready);
endinterface

// File: sv/point_in_polygon_crossing_test_unit.sv
// The last vertex passes the edge queue, the difference and product registers, then the verdict register.
// Throughput: one vertex per cycle while the four-word edge queue has room; it decouples intake from evaluation.
// Each word tests the incoming edge and, on the last vertex, the closing edge, in parallel.
// Reset clears the polygon state, the queue and the output; the query point resets to zero.
`timescale 1ns / 1ps
module point_in_polygon_crossing_test_unit #(
    parameter int COORD_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    pipct_vtx_if.sink               i_vtx,
    pipct_res_if.source             o_res,
    input  logic                    i_cfg_we,
    input  pipct_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [COORD_BITS-1:0]   i_cfg_data
);
    import pipct_pkg::*;

    localparam int WW = 6 * COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] r_query_x;
    logic signed [COORD_BITS-1:0] r_query_y;
    logic                         push;
    logic                         pop;
    logic                         full;
    logic                         empty;
    logic [WW-1:0]                push_word;
    logic [WW-1:0]                head_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_x <= '0;
            r_query_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUERY_X: r_query_x <= i_cfg_data;
                CFG_QUERY_Y: r_query_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pipct_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (i_vtx),
        .i_full  (full),
        .o_push  (push),
        .o_word  (push_word)
    );

    pipct_queue #(
        .WIDTH (WW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_word),
        .i_pop   (pop),
        .o_data  (head_word),
        .o_empty (empty),
        .o_full  (full)
    );

    pipct_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_word    (head_word),
        .i_empty   (empty),
        .o_pop     (pop),
        .i_query_x (r_query_x),
        .i_query_y (r_query_y),
        .o_res     (o_res)
    );
endmodule

// File: sv/pipct_front.sv
// Front end: takes vertices, tracks first and previous vertex, forms edge words.
`timescale 1ns / 1ps
module pipct_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    pipct_vtx_if.sink               i_vtx,
    input  logic                    i_full,
    output logic                    o_push,
    output logic [6*COORD_BITS+1:0] o_word
);
    localparam int CW = COORD_BITS;

    logic                 r_have;
    logic signed [CW-1:0] r_first_x;
    logic signed [CW-1:0] r_first_y;
    logic signed [CW-1:0] r_prev_x;
    logic signed [CW-1:0] r_prev_y;
    logic signed [CW-1:0] first_x_sel;
    logic signed [CW-1:0] first_y_sel;

    assign i_vtx.ready = !i_full;
    assign o_push      = i_vtx.valid && !i_full;

    always_comb begin
        first_x_sel = r_have ? r_first_x : i_vtx.vertex_x;
        first_y_sel = r_have ? r_first_y : i_vtx.vertex_y;
        o_word      = {r_prev_x, r_prev_y, i_vtx.vertex_x, i_vtx.vertex_y,
                       first_x_sel, first_y_sel, r_have, i_vtx.last_vertex};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (o_push) begin
            r_have <= !i_vtx.last_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            if (!r_have) begin
                r_first_x <= i_vtx.vertex_x;
                r_first_y <= i_vtx.vertex_y;
            end
            r_prev_x <= i_vtx.vertex_x;
            r_prev_y <= i_vtx.vertex_y;
        end
    end
endmodule

// File: sv/pipct_queue.sv
// Short first-in first-out queue of edge words between front and back end.
`timescale 1ns / 1ps
module pipct_queue #(
    parameter int WIDTH = 98,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wp;
    logic [AW:0]      r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW-1:0] == r_rp[AW-1:0]) && (r_wp[AW] != r_rp[AW]);
    assign o_data  = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[AW-1:0]] <= i_data;
        end
    end
endmodule

// File: sv/pipct_back.sv
// Back end: classify both edges, form cross products, fold parity and emit verdict.
`timescale 1ns / 1ps
module pipct_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [6*COORD_BITS+1:0]        i_word,
    input  logic                           i_empty,
    output logic                           o_pop,
    input  logic signed [COORD_BITS-1:0]   i_query_x,
    input  logic signed [COORD_BITS-1:0]   i_query_y,
    pipct_res_if.source                    o_res
);
    import pipct_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 2;

    logic signed [CW-1:0] w_px, w_py, w_cx, w_cy, w_fx, w_fy;
    logic                 w_has_a, w_last;

    logic signed [CW-1:0] x1 [NUM_EDGES];
    logic signed [CW-1:0] y1 [NUM_EDGES];
    logic signed [CW-1:0] x2 [NUM_EDGES];
    logic signed [CW-1:0] y2 [NUM_EDGES];
    logic                 en [NUM_EDGES];
    t_edge_flags          flags [NUM_EDGES];

    logic                 r_s1_valid;
    logic                 r_s1_last;
    t_edge_flags          r_s1_flags [NUM_EDGES];
    logic signed [DW-1:0] r_dx  [NUM_EDGES];
    logic signed [DW-1:0] r_dqy [NUM_EDGES];
    logic signed [DW-1:0] r_dy  [NUM_EDGES];
    logic signed [DW-1:0] r_dqx [NUM_EDGES];

    logic                 r_s2_valid;
    logic                 r_s2_last;
    t_edge_flags          r_s2_flags [NUM_EDGES];
    logic signed [PW-1:0] r_p1 [NUM_EDGES];
    logic signed [PW-1:0] r_p2 [NUM_EDGES];

    t_edge_verdict        verdict [NUM_EDGES];
    logic                 adv;
    logic                 n_par;
    logic                 n_hit;
    logic                 r_par;
    logic                 r_hit;
    logic                 r_out_valid;
    logic                 r_inside;
    logic                 r_on;

    assign {w_px, w_py, w_cx, w_cy, w_fx, w_fy, w_has_a, w_last} = i_word;

    assign adv   = !r_out_valid || o_res.ready;
    assign o_pop = adv && !i_empty;

    always_comb begin
        x1[EDGE_OPEN]  = w_px;
        y1[EDGE_OPEN]  = w_py;
        x2[EDGE_OPEN]  = w_cx;
        y2[EDGE_OPEN]  = w_cy;
        en[EDGE_OPEN]  = w_has_a;
        x1[EDGE_CLOSE] = w_cx;
        y1[EDGE_CLOSE] = w_cy;
        x2[EDGE_CLOSE] = w_fx;
        y2[EDGE_CLOSE] = w_fy;
        en[EDGE_CLOSE] = w_last;
    end

    always_comb begin
        for (int i = 0; i < NUM_EDGES; i++) begin
            logic span, left, right;
            span = ((y1[i] < i_query_y) && (i_query_y <= y2[i])) ||
                   ((y2[i] < i_query_y) && (i_query_y <= y1[i]));
            left  = (x1[i] <= i_query_x) && (x2[i] <= i_query_x);
            right = (i_query_x <= x1[i]) && (i_query_x <= x2[i]);
            flags[i].direct   = en[i] && span && left;
            flags[i].straddle = en[i] && span && !left && !right;
            flags[i].down     = y1[i] > y2[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= !i_empty;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_last <= w_last;
            r_s2_last <= r_s1_last;
            for (int i = 0; i < NUM_EDGES; i++) begin
                r_s1_flags[i] <= flags[i];
                r_dx[i]       <= DW'(x2[i]) - DW'(x1[i]);
                r_dqy[i]      <= DW'(i_query_y) - DW'(y1[i]);
                r_dy[i]       <= DW'(y2[i]) - DW'(y1[i]);
                r_dqx[i]      <= DW'(i_query_x) - DW'(x1[i]);
                r_s2_flags[i] <= r_s1_flags[i];
                r_p1[i]       <= PW'(r_dx[i]) * PW'(r_dqy[i]);
                r_p2[i]       <= PW'(r_dy[i]) * PW'(r_dqx[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_EDGES; i++) begin
            logic eq, gt;
            eq = (r_p1[i] == r_p2[i]);
            gt = (r_p1[i] > r_p2[i]);
            verdict[i].hit    = r_s2_flags[i].straddle && eq;
            verdict[i].toggle = r_s2_flags[i].direct ||
                                (r_s2_flags[i].straddle && !eq && (gt == r_s2_flags[i].down));
        end
        n_par = r_par ^ verdict[EDGE_OPEN].toggle ^ verdict[EDGE_CLOSE].toggle;
        n_hit = r_hit | verdict[EDGE_OPEN].hit | verdict[EDGE_CLOSE].hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par       <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                r_par <= r_s2_last ? 1'b0 : n_par;
                r_hit <= r_s2_last ? 1'b0 : n_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid && r_s2_last) begin
            r_inside <= n_par || n_hit;
            r_on     <= n_hit;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.inside_res = r_inside;
    assign o_res.on_contour = r_on;
endmodule

// File: sv/pipct_checker.sv
// Port-level checks on the crossing test unit, bound to its top level.
`timescale 1ns / 1ps
module pipct_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_vtx_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_inside_res,
    input logic i_on_contour
);
    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_vtx_ready)
        else $error("vertex intake not ready after reset");

    a_contour_is_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (!i_on_contour || i_inside_res))
        else $error("on contour without inside verdict");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_inside_res) && $stable(i_on_contour))
        else $error("stalled result changed");
endmodule

bind point_in_polygon_crossing_test_unit pipct_checker u_pipct_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_vtx_ready  (i_vtx.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_inside_res (o_res.inside_res),
    .i_on_contour (o_res.on_contour)
);
